[src/ltc_pkg.sv]
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared types, constants and codes for the push/pop trace checker.
// ----------------------------------------------------------------------------
package ltc_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;

    typedef enum logic [2:0] {
        V_STACK      = 3'd0,
        V_QUEUE      = 3'd1,
        V_PRIO       = 3'd2,
        V_IMPOSSIBLE = 3'd3,
        V_NOT_SURE   = 3'd4
    } t_verdict;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic              start_req;
        logic              op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic       stack_ok;
        logic       fifo_ok;
        logic       heap_ok;
        logic [2:0] verdict;
        logic       overflowed;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIMPLE,
        S_HPUSH_RD,
        S_HPUSH_CMP,
        S_HPOP_RDLAST,
        S_HPOP_RDC,
        S_HPOP_RDC2,
        S_HPOP_CMP,
        S_HPOP_RDTOP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat, apply start clear
        logic simple;    // lifo/fifo update, heap checks
        logic hpush_rd;  // read parent
        logic hpush_cmp; // compare and move or place
        logic hpop_last; // read last entry
        logic hpop_rdc;  // read left child
        logic hpop_rdc2; // read right child
        logic hpop_cmp;  // compare and move or place
        logic hpop_top;  // refresh cached top
        logic done;      // issue result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic heap_push;  // heap insert needed
        logic heap_pop;   // heap removal needed
        logic sift_end;   // sift finished this step
        logic has_c2;     // right child exists
    } t_sts;

    function automatic logic sgt(input logic [31:0] a, input logic [31:0] b);
        sgt = $signed(a) > $signed(b);
    endfunction

endpackage

[src/ltc_ctrl.sv]
// ----------------------------------------------------------------------------
// ltc_ctrl
// Sequencer: steps each beat through the store updates and the heap sift.
// ----------------------------------------------------------------------------
module ltc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ltc_pkg::t_sts  i_sts,
    output ltc_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    ltc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ltc_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ltc_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = ltc_pkg::S_SIMPLE;
                end
            end
            ltc_pkg::S_SIMPLE: begin
                o_cmd.simple = 1'b1;
                if (i_sts.heap_push)     n_state = ltc_pkg::S_HPUSH_RD;
                else if (i_sts.heap_pop) n_state = ltc_pkg::S_HPOP_RDLAST;
                else                     n_state = ltc_pkg::S_DONE;
            end
            ltc_pkg::S_HPUSH_RD: begin
                o_cmd.hpush_rd = 1'b1;
                if (i_sts.sift_end) n_state = ltc_pkg::S_HPOP_RDTOP;
                else                n_state = ltc_pkg::S_HPUSH_CMP;
            end
            ltc_pkg::S_HPUSH_CMP: begin
                o_cmd.hpush_cmp = 1'b1;
                if (i_sts.sift_end) n_state = ltc_pkg::S_HPOP_RDTOP;
                else                n_state = ltc_pkg::S_HPUSH_RD;
            end
            ltc_pkg::S_HPOP_RDLAST: begin
                o_cmd.hpop_last = 1'b1;
                if (i_sts.sift_end) n_state = ltc_pkg::S_HPOP_RDTOP;
                else                n_state = ltc_pkg::S_HPOP_RDC;
            end
            ltc_pkg::S_HPOP_RDC: begin
                o_cmd.hpop_rdc = 1'b1;
                if (i_sts.sift_end)    n_state = ltc_pkg::S_HPOP_RDTOP;
                else if (i_sts.has_c2) n_state = ltc_pkg::S_HPOP_RDC2;
                else                   n_state = ltc_pkg::S_HPOP_CMP;
            end
            ltc_pkg::S_HPOP_RDC2: begin
                o_cmd.hpop_rdc2 = 1'b1;
                n_state = ltc_pkg::S_HPOP_CMP;
            end
            ltc_pkg::S_HPOP_CMP: begin
                o_cmd.hpop_cmp = 1'b1;
                if (i_sts.sift_end) n_state = ltc_pkg::S_HPOP_RDTOP;
                else                n_state = ltc_pkg::S_HPOP_RDC;
            end
            ltc_pkg::S_HPOP_RDTOP: begin
                o_cmd.hpop_top = 1'b1;
                n_state = ltc_pkg::S_DONE;
            end
            ltc_pkg::S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = ltc_pkg::S_IDLE;
            end
            default: n_state = ltc_pkg::S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ltc_pkg::S_SIMPLE)
        else $error("load did not enter update step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> !o_busy)
        else $error("result step not followed by idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command at once");
endmodule

[src/ltc_dp.sv]
// ----------------------------------------------------------------------------
// ltc_dp
// Datapath: stack, ring queue and binary max-heap stores with flags.
// The heap top is cached in a register so pop checks need no read.
// ----------------------------------------------------------------------------
module ltc_dp #(
    parameter int DEPTH = ltc_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ltc_pkg::t_in   i_in,
    input  ltc_pkg::t_cmd  i_cmd,
    output ltc_pkg::t_sts  o_sts,
    output ltc_pkg::t_out  o_out
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [31:0] lifo_mem [DEPTH];
    logic [31:0] fifo_mem [DEPTH];
    logic [31:0] heap_mem [DEPTH];

    logic [31:0]   r_val;
    logic          r_pop;
    logic [CW-1:0] r_lcnt, r_fcnt, r_hcnt;
    logic [AW-1:0] r_fhead;
    logic          r_lok, r_fok, r_hok, r_ovf;
    logic [31:0]   r_ltop;   // stack top, read after each push/pop
    logic [31:0]   r_ffront; // queue front
    logic [31:0]   r_htop;
    logic [AW:0]   r_i;      // sift position (one spare bit for child calc)
    logic [31:0]   r_key;    // value being placed
    logic [31:0]   r_rd, r_rd2;
    logic [AW:0]   r_c;

    // ------------------------------------------------------------------
    // combinational helpers
    logic [AW:0] w_par, w_c1, w_c2;
    logic [AW:0] w_hcnt;
    assign w_hcnt = (AW+1)'(r_hcnt);
    assign w_par  = (r_i - 1'b1) >> 1;
    assign w_c1   = {r_i[AW-1:0], 1'b1};
    assign w_c2   = w_c1 + 1'b1;

    logic w_l_ok, w_f_ok, w_h_ok;
    assign w_l_ok = r_lcnt != '0 && r_ltop == r_val;
    assign w_f_ok = r_fcnt != '0 && r_ffront == r_val;
    assign w_h_ok = r_hcnt != '0 && r_htop == r_val;

    logic [AW-1:0] w_ftail;
    logic [AW:0]   w_tsum;
    assign w_tsum  = (AW+1)'(r_fhead) + (AW+1)'(r_fcnt);
    assign w_ftail = (w_tsum >= (AW+1)'(DEPTH)) ? AW'(w_tsum - (AW+1)'(DEPTH))
                                               : AW'(w_tsum);

    logic [AW-1:0] w_fhead_nx;
    assign w_fhead_nx = (r_fhead == AW'(DEPTH - 1)) ? '0 : r_fhead + 1'b1;

    // status
    logic w_cbig; // chosen child beats key
    logic [31:0] w_cval;
    logic [AW:0] w_csel;
    always_comb begin
        w_cval = r_rd;
        w_csel = r_c;
        if (r_c + 1'b1 < w_hcnt && ltc_pkg::sgt(r_rd2, r_rd)) begin
            w_cval = r_rd2;
            w_csel = r_c + 1'b1;
        end
        w_cbig = ltc_pkg::sgt(w_cval, r_key);
    end

    // heap work is decided from the counts before the update step
    always_comb begin
        o_sts = '0;
        o_sts.heap_push = !r_pop && r_hok && r_hcnt != FULL;
        o_sts.heap_pop  = r_pop && r_hok && w_h_ok && r_hcnt != CW'(1);
        o_sts.has_c2    = w_c2 < w_hcnt;
        if (i_cmd.hpush_rd)  o_sts.sift_end = r_i == '0;
        if (i_cmd.hpush_cmp) o_sts.sift_end = !ltc_pkg::sgt(r_key, r_rd);
        if (i_cmd.hpop_rdc)  o_sts.sift_end = w_c1 >= w_hcnt;
        if (i_cmd.hpop_cmp)  o_sts.sift_end = !w_cbig;
    end

    // ------------------------------------------------------------------
    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.simple && !r_pop && r_lok && r_lcnt != FULL)
            lifo_mem[AW'(r_lcnt)] <= r_val;
        if (i_cmd.simple && !r_pop && r_fok && r_fcnt != FULL)
            fifo_mem[w_ftail] <= r_val;
    end

    // stack/queue head refresh: read after count update (next cycle)
    logic r_rf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rf <= 1'b0;
        else          r_rf <= i_cmd.simple;
        if (r_rf) begin
            r_ltop   <= (r_lcnt != '0) ? lifo_mem[AW'(r_lcnt - 1'b1)] : r_ltop;
            r_ffront <= fifo_mem[r_fhead];
        end
    end

    // heap store: one read address, one write address per cycle
    logic [AW-1:0] w_haddr;
    always_comb begin
        w_haddr = '0;
        if (i_cmd.hpush_rd)  w_haddr = AW'(w_par);
        if (i_cmd.hpop_last) w_haddr = AW'(r_hcnt);
        if (i_cmd.hpop_rdc)  w_haddr = AW'(w_c1);
        if (i_cmd.hpop_rdc2) w_haddr = AW'(r_c + 1'b1);
    end

    logic          w_hwe;
    logic [AW-1:0] w_hwaddr;
    logic [31:0]   w_hwdata;
    always_comb begin
        w_hwe    = 1'b0;
        w_hwaddr = AW'(r_i);
        w_hwdata = r_key;
        if (i_cmd.hpush_rd && r_i == '0) w_hwe = 1'b1;
        if (i_cmd.hpush_cmp) begin
            w_hwe = 1'b1;
            if (ltc_pkg::sgt(r_key, r_rd)) w_hwdata = r_rd;
        end
        if (i_cmd.hpop_rdc && w_c1 >= w_hcnt) w_hwe = 1'b1;
        if (i_cmd.hpop_cmp) begin
            w_hwe = 1'b1;
            if (w_cbig) w_hwdata = w_cval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hpush_rd || i_cmd.hpop_rdc)
            r_rd <= heap_mem[w_haddr];
        if (i_cmd.hpop_rdc2)
            r_rd2 <= heap_mem[w_haddr];
        if (i_cmd.hpop_top)
            r_htop <= heap_mem[w_haddr];
        if (i_cmd.simple)
            r_key <= r_val;
        // take the last entry as the key to sift down from the root
        if (i_cmd.hpop_last)
            r_key <= heap_mem[w_haddr];
        if (w_hwe)
            heap_mem[w_hwaddr] <= w_hwdata;
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcnt <= '0; r_fcnt <= '0; r_hcnt <= '0; r_fhead <= '0;
            r_lok <= 1'b1; r_fok <= 1'b1; r_hok <= 1'b1; r_ovf <= 1'b0;
            r_pop <= 1'b0;
            r_i <= '0; r_c <= '0;
        end else begin
            if (i_cmd.load) begin
                r_val <= i_in.value;
                r_pop <= i_in.op == ltc_pkg::OP_POP;
                if (i_in.start_req) begin
                    r_lcnt <= '0; r_fcnt <= '0; r_hcnt <= '0; r_fhead <= '0;
                    r_lok <= 1'b1; r_fok <= 1'b1; r_hok <= 1'b1; r_ovf <= 1'b0;
                end
            end
            if (i_cmd.simple) begin
                if (!r_pop) begin
                    if (r_lok) begin
                        if (r_lcnt != FULL) r_lcnt <= r_lcnt + 1'b1;
                        else                r_ovf <= 1'b1;
                    end
                    if (r_fok) begin
                        if (r_fcnt != FULL) r_fcnt <= r_fcnt + 1'b1;
                        else                r_ovf <= 1'b1;
                    end
                    if (r_hok) begin
                        if (r_hcnt != FULL) begin
                            r_hcnt  <= r_hcnt + 1'b1;
                            r_i     <= (AW+1)'(r_hcnt);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end else begin
                    if (r_fok) begin
                        if (w_f_ok) begin
                            r_fhead <= w_fhead_nx;
                            r_fcnt  <= r_fcnt - 1'b1;
                        end else r_fok <= 1'b0;
                    end
                    if (r_lok) begin
                        if (w_l_ok) r_lcnt <= r_lcnt - 1'b1;
                        else        r_lok <= 1'b0;
                    end
                    if (r_hok) begin
                        if (w_h_ok) begin
                            r_hcnt <= r_hcnt - 1'b1;
                            r_i    <= '0;
                        end else r_hok <= 1'b0;
                    end
                end
            end
            if (i_cmd.hpush_cmp && ltc_pkg::sgt(r_key, r_rd))
                r_i <= w_par;
            if (i_cmd.hpop_rdc)
                r_c <= w_c1;
            if (i_cmd.hpop_cmp && w_cbig)
                r_i <= w_csel;
        end
    end

    // ------------------------------------------------------------------
    // result
    always_comb begin
        o_out.stack_ok   = r_lok;
        o_out.fifo_ok    = r_fok;
        o_out.heap_ok    = r_hok;
        o_out.overflowed = r_ovf;
        if (r_lok && !r_fok && !r_hok)       o_out.verdict = ltc_pkg::V_STACK;
        else if (r_fok && !r_lok && !r_hok)  o_out.verdict = ltc_pkg::V_QUEUE;
        else if (r_hok && !r_lok && !r_fok)  o_out.verdict = ltc_pkg::V_PRIO;
        else if (!r_lok && !r_fok && !r_hok) o_out.verdict = ltc_pkg::V_IMPOSSIBLE;
        else                                 o_out.verdict = ltc_pkg::V_NOT_SURE;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcnt <= FULL && r_fcnt <= FULL && r_hcnt <= FULL)
        else $error("store count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.simple && !r_lok |=> !r_lok)
        else $error("ruled-out stack revived within a sequence");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hpush_cmp |-> r_i != '0)
        else $error("heap sift-up compare at root");
endmodule

[src/lifo_fifo_heap_trace_checker_top.sv]
// ----------------------------------------------------------------------------
// lifo_fifo_heap_trace_checker_top
// Checks a push/pop trace against stack, queue and max-heap disciplines.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------
//  command  | start / busy        | i_cmd  (ltc_pkg::t_in)
//  result   | o_done strobe       | o_result (ltc_pkg::t_out)
//
// A beat with no heap work steps from idle through the update and result states
// before the next acceptance. A heap push adds a parent read and a compare per
// level climbed; a heap pop reads the last entry, then the children and a compare
// per level descended; both then refresh the cached heap top.
// Synchronous reset clears counts and flags; stores need no clearing.
// o_done pulses for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module lifo_fifo_heap_trace_checker_top #(
    parameter int DEPTH = ltc_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ltc_pkg::t_in  i_cmd,
    output logic          o_done,
    output ltc_pkg::t_out o_result
);
    ltc_pkg::t_cmd w_cmd;
    ltc_pkg::t_sts w_sts;

    ltc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd),
        .o_busy (busy)
    );

    ltc_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_cmd),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_out  (o_result)
    );

    assign o_done = w_cmd.done;
endmodule

[test/tb_lifo_fifo_heap_trace_checker_top.sv]
// ----------------------------------------------------------------------------
// tb_lifo_fifo_heap_trace_checker_top
// Drives push/pop traces into the trace checker and compares every result
// beat with a behavioural model of the stack, queue and max-heap disciplines.
// ----------------------------------------------------------------------------
module tb_lifo_fifo_heap_trace_checker_top;
    import ltc_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    t_in   i_cmd = '0;
    logic  o_done;
    t_out  o_result;

    lifo_fifo_heap_trace_checker_top #(.DEPTH(DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // model state
    logic [31:0] stk_mem [DEPTH];
    int          stk_cnt;
    logic [31:0] que_mem [DEPTH];
    int          que_head, que_cnt;
    logic signed [31:0] pq_mem [$];
    logic        stk_ok, que_ok, pq_ok, ovf_seen;

    t_in   pending_cmds [$];
    t_out  expected_results [$];
    int    errors = 0;
    int    cycles = 0;
    int    gap = 0;
    bit    stim_done = 0;
    bit    hold_for_drain = 0;

    // queue of values, declared but not used by the stimulus
    logic [31:0] shadow [$];

    function automatic void model_clear();
        stk_cnt = 0; que_head = 0; que_cnt = 0;
        pq_mem.delete();
        stk_ok = 1; que_ok = 1; pq_ok = 1; ovf_seen = 0;
    endfunction

    function automatic t_out trace_predict(t_in c);
        t_out r;
        int   top_i;
        if (c.start_req) model_clear();
        if (c.op == OP_PUSH) begin
            if (stk_ok) begin
                if (stk_cnt < DEPTH) begin
                    stk_mem[stk_cnt] = c.value; stk_cnt++;
                end else ovf_seen = 1;
            end
            if (que_ok) begin
                if (que_cnt < DEPTH) begin
                    que_mem[(que_head + que_cnt) % DEPTH] = c.value; que_cnt++;
                end else ovf_seen = 1;
            end
            if (pq_ok) begin
                if (pq_mem.size() < DEPTH) pq_mem.push_back(c.value);
                else ovf_seen = 1;
            end
        end else begin
            if (que_ok) begin
                if (que_cnt > 0 && que_mem[que_head] == c.value) begin
                    que_head = (que_head + 1) % DEPTH; que_cnt--;
                end else que_ok = 0;
            end
            if (stk_ok) begin
                if (stk_cnt > 0 && stk_mem[stk_cnt-1] == c.value) stk_cnt--;
                else stk_ok = 0;
            end
            if (pq_ok) begin
                top_i = -1;
                foreach (pq_mem[k])
                    if (top_i < 0 || pq_mem[k] > pq_mem[top_i]) top_i = k;
                if (top_i >= 0 && pq_mem[top_i] == $signed(c.value))
                    pq_mem.delete(top_i);
                else pq_ok = 0;
            end
        end
        r.stack_ok = stk_ok; r.fifo_ok = que_ok; r.heap_ok = pq_ok;
        r.overflowed = ovf_seen;
        if (stk_ok && !que_ok && !pq_ok)      r.verdict = V_STACK;
        else if (que_ok && !stk_ok && !pq_ok) r.verdict = V_QUEUE;
        else if (pq_ok && !stk_ok && !que_ok) r.verdict = V_PRIO;
        else if (!stk_ok && !que_ok && !pq_ok) r.verdict = V_IMPOSSIBLE;
        else                                  r.verdict = V_NOT_SURE;
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_cmd(bit s, t_op o, logic [31:0] v);
        t_in c;
        c.start_req = s; c.op = o; c.value = v;
        pending_cmds.push_back(c);
    endfunction

    // one sequence following a stack, queue or heap discipline, with the odd pop corrupted
    task automatic add_sequence(int kind, int n);
        logic [31:0] held [$];
        logic [31:0] v;
        int          idx;
        held.delete();
        add_cmd(1, OP_PUSH, rand_value());
        held.push_back(pending_cmds[$].value);
        repeat (n) begin
            if (held.size() == 0 || ($urandom_range(0, 1) && held.size() < 70)) begin
                v = ($urandom_range(0, 3) == 0) ? held[$] : rand_value();
                add_cmd(0, OP_PUSH, v);
                held.push_back(v);
            end else begin
                if (kind == 0) begin
                    v = held.pop_back();
                end else if (kind == 1) begin
                    v = held.pop_front();
                end else begin
                    idx = 0;
                    foreach (held[k]) if ($signed(held[k]) > $signed(held[idx])) idx = k;
                    v = held[idx]; held.delete(idx);
                end
                // corrupt the odd pop
                if ($urandom_range(0, 19) == 0) v = rand_value();
                add_cmd(0, OP_POP, v);
            end
        end
    endtask

    // driver: hold start until the beat is taken, then idle for a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            // beat accepted this edge
            if (gap == 0 && pending_cmds.size() > 0 && !hold_for_drain) begin
                i_cmd <= pending_cmds.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (gap > 0) gap <= gap - 1;
            else if (pending_cmds.size() > 0 && !hold_for_drain) begin
                i_cmd <= pending_cmds.pop_front();
                start <= 1'b1;
                gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                       ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
            end
        end
    end

    // predict on acceptance, check on strobe
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (start && !busy) expected_results.push_back(trace_predict(i_cmd));
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_result);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_result !== exp_r) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_r, o_result);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        model_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, empty pops, a ruled-out push and heap sign order
        add_cmd(0, OP_POP, 32'h0);
        add_cmd(0, OP_PUSH, 32'h0);
        add_cmd(1, OP_PUSH, 32'h8000_0000);
        add_cmd(0, OP_PUSH, 32'h7fff_ffff);
        add_cmd(0, OP_PUSH, 32'hffff_ffff);
        add_cmd(0, OP_POP, 32'h7fff_ffff);
        add_cmd(0, OP_PUSH, 32'h1234_5678);
        add_cmd(0, OP_POP, 32'h1234_5678);
        add_cmd(0, OP_POP, 32'hffff_ffff);
        add_cmd(0, OP_POP, 32'h8000_0000);
        add_cmd(0, OP_POP, 32'h5555_aaaa);
        add_cmd(0, OP_PUSH, 32'haaaa_5555);
        add_cmd(1, OP_PUSH, 32'h1);
        add_cmd(0, OP_PUSH, 32'h2);
        add_cmd(0, OP_POP, 32'h1);
        add_cmd(0, OP_POP, 32'h2);
        // fill past capacity to set the overflow flag
        add_cmd(1, OP_PUSH, $urandom);
        repeat (66) add_cmd(0, OP_PUSH, $urandom);
        add_cmd(0, OP_POP, 32'h0);
        wait (pending_cmds.size() == 0 && !start);
        hold_for_drain = 1;
        wait (expected_results.size() == 0);
        hold_for_drain = 0;

        for (int k = 0; k < 69; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 10))
                    add_cmd($urandom_range(0, 7) == 0, t_op'($urandom_range(0, 1)),
                            rand_value());
            end else begin
                add_sequence($urandom_range(0, 2), $urandom_range(4, 40));
            end
        end
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[lifo_fifo_heap_trace_checker_top.f]
src/ltc_pkg.sv
src/ltc_ctrl.sv
src/ltc_dp.sv
src/lifo_fifo_heap_trace_checker_top.sv
test/tb_lifo_fifo_heap_trace_checker_top.sv
